### rtl/core/sbx_pkg.sv
// Package for the serial buffer block with XON/XOFF flow control.
// Holds the sizes, character codes, item types and ring pointer helpers.
// Depends on nothing.
`timescale 1ns / 1ps

package sbx_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int CMP_W        = (PTR_W > 6) ? PTR_W : 6;

  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(BUFFER_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(BUFFER_DEPTH - 1);

  localparam logic [7:0] CHAR_XON  = 8'd17;
  localparam logic [7:0] CHAR_XOFF = 8'd19;

  localparam logic [2:0] FLAGS_NONE     = 3'b000;
  localparam logic [2:0] FLAG_SEND_XON  = 3'b001;
  localparam logic [2:0] FLAG_SEND_XOFF = 3'b010;
  localparam logic [2:0] FLAG_STATE_XON = 3'b100;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_EN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = CFG_IDX_W'(1);
  localparam logic [5:0] THRESH_RESET = 6'd16;

  typedef enum logic [1:0] {
    OP_RX_BYTE    = 2'd0,
    OP_TX_SLOT    = 2'd1,
    OP_HOST_READ  = 2'd2,
    OP_HOST_WRITE = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } state_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] data_byte;
  } sbx_in_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       write_accepted;
    logic       rx_dropped;
    logic [5:0] rx_fill;
    logic [5:0] tx_fill;
    logic       send_request;
  } sbx_out_t;

  typedef struct packed {
    logic       use_tx_data;
    logic       use_rx_data;
    sbx_out_t   res;
  } step_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
    return (p == LAST_P) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_fill(logic [PTR_W-1:0] w, logic [PTR_W-1:0] r);
    return (w >= r) ? w - r : w - r + DEPTH_P;
  endfunction

  function automatic logic [PTR_W-1:0] ring_free(logic [PTR_W-1:0] w, logic [PTR_W-1:0] r);
    return LAST_P - ring_fill(w, r);
  endfunction

  function automatic logic at_or_below(logic [PTR_W-1:0] v, logic [5:0] thr);
    return CMP_W'(v) <= CMP_W'(thr);
  endfunction

  function automatic logic [5:0] fill6(logic [PTR_W-1:0] v);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(v);
    return ext[5:0];
  endfunction

endpackage

### rtl/core/sbx_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the receive and transmit byte stores. No dependencies.
`timescale 1ns / 1ps

module sbx_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/sbx_ctrl.sv
// Ring pointer, flow flag and send request control for the serial buffers.
// Issues store accesses per item and keeps the partial result. Uses sbx_pkg.
`timescale 1ns / 1ps

module sbx_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  sbx_pkg::sbx_in_t item,
  input  logic             flow_en,
  input  logic [5:0]       flow_thresh,
  output sbx_pkg::ram_req_t rx_req,
  output sbx_pkg::ram_req_t tx_req,
  output sbx_pkg::step_t    step
);
  import sbx_pkg::*;

  logic [PTR_W-1:0] rx_wptr_r, rx_wptr_nxt, rx_rptr_r, rx_rptr_nxt;
  logic [PTR_W-1:0] tx_wptr_r, tx_wptr_nxt, tx_rptr_r, tx_rptr_nxt;
  logic [2:0]       flags_r, flags_nxt;
  logic             send_en_r, send_en_nxt;
  step_t            step_r, step_nxt;

  always_comb begin
    logic [PTR_W-1:0] rx_fill_cur, tx_fill_cur;
    rx_fill_cur = ring_fill(rx_wptr_r, rx_rptr_r);
    tx_fill_cur = ring_fill(tx_wptr_r, tx_rptr_r);
    rx_wptr_nxt = rx_wptr_r;
    rx_rptr_nxt = rx_rptr_r;
    tx_wptr_nxt = tx_wptr_r;
    tx_rptr_nxt = tx_rptr_r;
    flags_nxt   = flags_r;
    send_en_nxt = send_en_r;
    rx_req      = '{we: 1'b0, waddr: rx_wptr_r, wdata: item.data_byte,
                    re: 1'b0, raddr: rx_rptr_r};
    tx_req      = '{we: 1'b0, waddr: tx_wptr_r, wdata: item.data_byte,
                    re: 1'b0, raddr: tx_rptr_r};
    step_nxt    = '0;
    if (accept) begin
      unique case (item.operation)
        OP_RX_BYTE: begin
          if (rx_fill_cur != LAST_P) begin
            rx_req.we   = 1'b1;
            rx_wptr_nxt = ptr_next(rx_wptr_r);
          end else begin
            step_nxt.res.rx_dropped = 1'b1;
          end
          if (flow_en && flags_r[2] &&
              at_or_below(ring_free(rx_wptr_nxt, rx_rptr_r), flow_thresh)) begin
            flags_nxt   = FLAG_SEND_XOFF | FLAG_STATE_XON;
            send_en_nxt = 1'b1;
          end
        end
        OP_TX_SLOT: begin
          if (send_en_r) begin
            priority if (flow_en && flags_r[0]) begin
              step_nxt.res.send_valid = 1'b1;
              step_nxt.res.send_byte  = CHAR_XON;
              flags_nxt               = FLAG_STATE_XON;
            end else if (flow_en && flags_r[1]) begin
              step_nxt.res.send_valid = 1'b1;
              step_nxt.res.send_byte  = CHAR_XOFF;
              flags_nxt               = FLAGS_NONE;
            end else if (tx_fill_cur != '0) begin
              step_nxt.res.send_valid = 1'b1;
              step_nxt.use_tx_data    = 1'b1;
              tx_req.re               = 1'b1;
              tx_rptr_nxt             = ptr_next(tx_rptr_r);
            end else begin
              send_en_nxt = 1'b0;
            end
          end
        end
        OP_HOST_READ: begin
          if (rx_fill_cur != '0) begin
            step_nxt.res.read_valid = 1'b1;
            step_nxt.use_rx_data    = 1'b1;
            rx_req.re               = 1'b1;
            rx_rptr_nxt             = ptr_next(rx_rptr_r);
          end
          if (flow_en && !flags_r[2] &&
              at_or_below(ring_fill(rx_wptr_r, rx_rptr_nxt), flow_thresh)) begin
            flags_nxt   = FLAG_SEND_XON;
            send_en_nxt = 1'b1;
          end
        end
        OP_HOST_WRITE: begin
          if (tx_fill_cur != LAST_P) begin
            tx_req.we                   = 1'b1;
            tx_wptr_nxt                 = ptr_next(tx_wptr_r);
            step_nxt.res.write_accepted = 1'b1;
          end
          send_en_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
    step_nxt.res.rx_fill      = fill6(ring_fill(rx_wptr_nxt, rx_rptr_nxt));
    step_nxt.res.tx_fill      = fill6(ring_fill(tx_wptr_nxt, tx_rptr_nxt));
    step_nxt.res.send_request = send_en_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wptr_r <= '0;
      rx_rptr_r <= '0;
      tx_wptr_r <= '0;
      tx_rptr_r <= '0;
      flags_r   <= FLAG_SEND_XON;
      send_en_r <= 1'b1;
    end else begin
      rx_wptr_r <= rx_wptr_nxt;
      rx_rptr_r <= rx_rptr_nxt;
      tx_wptr_r <= tx_wptr_nxt;
      tx_rptr_r <= tx_rptr_nxt;
      flags_r   <= flags_nxt;
      send_en_r <= send_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step_r <= step_nxt;
    end
  end

  assign step = step_r;

  a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({rx_req.we, rx_req.re, tx_req.we, tx_req.re}) <= 1)
    else $error("more than one store access for one item");

  a_no_idle_access: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> !(rx_req.we || rx_req.re || tx_req.we || tx_req.re))
    else $error("store accessed without an accepted item");

  a_tx_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    tx_req.we |=> ring_fill(tx_wptr_r, tx_rptr_r) ==
                  $past(ring_fill(tx_wptr_r, tx_rptr_r)) + PTR_W'(1))
    else $error("transmit fill did not grow by one after a push");

endmodule

### rtl/core/serial_buffers_xon_xoff.sv
// Top level of the serial receive/transmit buffers with XON/XOFF flow control.
// Instantiates sbx_ctrl and two sbx_ram stores; uses sbx_pkg.
`timescale 1ns / 1ps

// The pointers, flags and store access are resolved in the cycle the item is
// accepted; the result is formed in ST_LOAD once the registered read data of
// the byte store has arrived and the output register is free. The result
// then sits in an output register, so a new item is accepted while an
// earlier result still waits to be taken. Configuration writes are always
// ready and take effect at once; there is no clearing pass after reset.

module serial_buffers_xon_xoff (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sbx_pkg::sbx_in_t                   in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sbx_pkg::sbx_out_t                  out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sbx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbx_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sbx_pkg::*;

  state_t     state_r, state_nxt;
  logic       flow_en_r, flow_en_nxt;
  logic [5:0] thresh_r, thresh_nxt;
  logic       out_valid_r, out_valid_nxt;
  sbx_out_t   out_item_r, out_item_nxt;
  logic       accept, load;
  ram_req_t   rx_req, tx_req;
  step_t      step;
  logic [7:0] rx_rdata, tx_rdata;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    flow_en_nxt = flow_en_r;
    thresh_nxt  = thresh_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FLOW_EN) begin
        flow_en_nxt = cfg_data[0];
      end else if (cfg_index == CFG_THRESH) begin
        thresh_nxt = cfg_data[5:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    load     = (state_r == ST_LOAD) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (load) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt           = step.res;
      if (step.use_tx_data) begin
        out_item_nxt.send_byte = tx_rdata;
      end
      if (step.use_rx_data) begin
        out_item_nxt.read_byte = rx_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flow_en_r   <= 1'b1;
      thresh_r    <= THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flow_en_r   <= flow_en_nxt;
      thresh_r    <= thresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  sbx_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (in_item),
    .flow_en     (flow_en_r),
    .flow_thresh (thresh_r),
    .rx_req      (rx_req),
    .tx_req      (tx_req),
    .step        (step)
  );

  sbx_ram #(.DEPTH(BUFFER_DEPTH), .WIDTH(8)) u_rx_ram (
    .clk   (clk),
    .we    (rx_req.we),
    .waddr (rx_req.waddr),
    .wdata (rx_req.wdata),
    .re    (rx_req.re),
    .raddr (rx_req.raddr),
    .rdata (rx_rdata)
  );

  sbx_ram #(.DEPTH(BUFFER_DEPTH), .WIDTH(8)) u_tx_ram (
    .clk   (clk),
    .we    (tx_req.we),
    .waddr (tx_req.waddr),
    .wdata (tx_req.wdata),
    .re    (tx_req.re),
    .raddr (tx_req.raddr),
    .rdata (tx_rdata)
  );

  a_accept_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_LOAD)
    else $error("accepted item did not move to the result stage");

  a_load_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r && state_r == ST_IDLE)
    else $error("result stage did not hand its item to the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !load)
    else $error("pending result overwritten while stalled");

endmodule
